// ----- hdl/i2cmw_pkg.sv -----
// Shared types and constants for the I2C master register write block.
package i2cmw_pkg;

    // Width of the acknowledge timeout register.
    localparam int CFG_W = 16;

    // Timeout limit after reset, in ticks.
    localparam logic [CFG_W-1:0] ACK_LIMIT_RESET = 16'd500;

    // Bit width of one tdata word on the result side.
    localparam int RES_TDATA_W = 8;

    // Line levels and status for one tick, scl_level in the lowest bit.
    typedef struct packed {
        logic nack;
        logic done_res;
        logic busy_res;
        logic sda_drive;
        logic sda_level;
        logic scl_level;
    } i2cmw_res_t;

endpackage

// ----- hdl/i2c_master_register_write.sv -----
// I2C master register write: each input word is one half-bit tick and returns one
// result word with the SCL/SDA levels for that tick. An idle block given cmd=1 sends
// a start, the device address, register index and data byte (MSB first), waits up to
// ack_timeout_limit high SDA samples for each acknowledge, and ends with a stop and
// a done pulse, with nack set if an acknowledge timed out. One tick is accepted every
// clock cycle; its result appears in the output register on the next cycle. The rate
// is set by that single output register: input is held off only while a result
// waits there and the downstream side is not ready.
module i2c_master_register_write #(
    parameter int TIMEOUT_COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Tick input.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] device_address, [15:8] register_index, [23:16] data_byte, [24] sda_in
    input  logic [31:0]                     s_axis_tdata,
    // [0] cmd
    input  logic [0:0]                      s_axis_tuser,
    // Result output.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res, [5] nack
    output logic [i2cmw_pkg::RES_TDATA_W-1:0] m_axis_tdata,
    // Timeout limit write.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2cmw_pkg::CFG_W-1:0]     cfg_data
);
    import i2cmw_pkg::*;

    logic             accept;
    logic [CFG_W-1:0] limit_reg;
    logic             out_valid_reg;
    i2cmw_res_t       res;
    i2cmw_res_t       out_res_reg;

    // A word enters whenever the result register is free or being emptied.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Timeout limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ACK_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    i2cmw_fsm #(
        .TIMEOUT_COUNT_WIDTH (TIMEOUT_COUNT_WIDTH)
    ) u_fsm (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (accept),
        .cmd               (s_axis_tuser[0]),
        .device_address    (s_axis_tdata[7:0]),
        .register_index    (s_axis_tdata[15:8]),
        .data_byte         (s_axis_tdata[23:16]),
        .sda_in            (s_axis_tdata[24]),
        .ack_timeout_limit (limit_reg),
        .res               (res)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(RES_TDATA_W - $bits(i2cmw_res_t)){1'b0}}, out_res_reg};

`ifndef SYNTHESIS
    // The ending tick never reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
        else $error("done and busy in the same result word");

    // A nack is only reported on the ending tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[4])
        else $error("nack without done");

    // SDA is only released while SCL is high for the acknowledge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[0] && m_axis_tdata[3]))
        else $error("SDA released outside the acknowledge");

    // A held result word blocks new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a result word is stalled");
`endif

endmodule

// ----- hdl/i2cmw_fsm.sv -----
// Transaction sequencer: holds the write state and computes each tick's line levels.
module i2cmw_fsm #(
    parameter int TIMEOUT_COUNT_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    cmd,
    input  logic [7:0]              device_address,
    input  logic [7:0]              register_index,
    input  logic [7:0]              data_byte,
    input  logic                    sda_in,
    input  logic [i2cmw_pkg::CFG_W-1:0] ack_timeout_limit,
    output i2cmw_pkg::i2cmw_res_t   res
);
    import i2cmw_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START_A  = 4'd1;
    localparam logic [3:0] PH_START_B  = 4'd2;
    localparam logic [3:0] PH_BIT_LOW  = 4'd3;
    localparam logic [3:0] PH_BIT_HIGH = 4'd4;
    localparam logic [3:0] PH_ACK      = 4'd5;
    localparam logic [3:0] PH_STOP_A   = 4'd6;
    localparam logic [3:0] PH_STOP_B   = 4'd7;

    localparam logic [2:0] LAST_BIT  = 3'd7;
    localparam logic [1:0] LAST_BYTE = 2'd2;

    localparam int TW    = TIMEOUT_COUNT_WIDTH;
    localparam int CMP_W = (TW > CFG_W) ? TW : CFG_W;

    logic [3:0]    phase_reg, phase_next;
    logic [1:0]    byte_reg, byte_next;
    logic [2:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    logic [7:0]    held_reg_reg, held_reg_next;
    logic [7:0]    held_data_reg, held_data_next;
    logic [TW-1:0] ack_cnt_reg, ack_cnt_next;
    logic          failed_reg, failed_next;
    logic          done_next;
    logic          ack_expired;

    // The limit is reached at the configured count or when the counter is full.
    assign ack_expired = (CMP_W'(ack_cnt_reg) >= CMP_W'(ack_timeout_limit))
                      || (ack_cnt_reg == {TW{1'b1}});

    // Next state for one tick.
    always_comb
    begin
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        held_reg_next  = held_reg_reg;
        held_data_next = held_data_reg;
        ack_cnt_next   = ack_cnt_reg;
        failed_next    = failed_reg;
        done_next      = 1'b0;
        case (phase_reg)
            PH_START_A:  phase_next = PH_START_B;
            PH_START_B:  phase_next = PH_BIT_LOW;
            PH_BIT_LOW:  phase_next = PH_BIT_HIGH;
            PH_BIT_HIGH:
            begin
                if (bit_reg == LAST_BIT)
                begin
                    bit_next     = '0;
                    ack_cnt_next = '0;
                    phase_next   = PH_ACK;
                end
                else
                begin
                    bit_next   = bit_reg + 3'd1;
                    shift_next = {shift_reg[6:0], 1'b0};
                    phase_next = PH_BIT_LOW;
                end
            end
            PH_ACK:
            begin
                if (!sda_in)
                begin
                    if (byte_reg >= LAST_BYTE)
                    begin
                        phase_next = PH_STOP_A;
                    end
                    else
                    begin
                        byte_next  = byte_reg + 2'd1;
                        shift_next = (byte_reg == 2'd0) ? held_reg_reg : held_data_reg;
                        bit_next   = '0;
                        phase_next = PH_BIT_LOW;
                    end
                end
                else if (ack_expired)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_STOP_A;
                end
                else
                begin
                    ack_cnt_next = ack_cnt_reg + TW'(1);
                end
            end
            PH_STOP_A:   phase_next = PH_STOP_B;
            PH_STOP_B:
            begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                // Idle, and any unused code behaves as idle.
                phase_next = PH_IDLE;
                if (cmd)
                begin
                    shift_next     = device_address;
                    held_reg_next  = register_index;
                    held_data_next = data_byte;
                    byte_next      = '0;
                    bit_next       = '0;
                    ack_cnt_next   = '0;
                    failed_next    = 1'b0;
                    phase_next     = PH_START_A;
                end
            end
        endcase
    end

    // Line levels follow the state entered on this tick.
    always_comb
    begin
        res           = '0;
        res.sda_drive = 1'b1;
        res.busy_res  = 1'b1;
        res.done_res  = done_next;
        res.nack      = done_next & failed_next;
        case (phase_next)
            PH_START_A:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
            end
            PH_START_B:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            PH_BIT_LOW:
            begin
                res.scl_level = 1'b0;
                res.sda_level = shift_next[7];
            end
            PH_BIT_HIGH:
            begin
                res.scl_level = 1'b1;
                res.sda_level = shift_next[7];
            end
            PH_ACK:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
                res.sda_drive = 1'b0;
            end
            PH_STOP_A:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            PH_STOP_B:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            default:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
                res.busy_res  = 1'b0;
            end
        endcase
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            byte_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            held_reg_reg  <= '0;
            held_data_reg <= '0;
            ack_cnt_reg   <= '0;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            byte_reg      <= byte_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            held_reg_reg  <= held_reg_next;
            held_data_reg <= held_data_next;
            ack_cnt_reg   <= ack_cnt_next;
            failed_reg    <= failed_next;
        end
    end

endmodule
